>>> rtl/core/rsd_pkg.sv
package rsd_pkg;

  localparam int MAX_RECORDS = 32;
  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  typedef struct packed {
    logic [15:0]        record_id;
    logic signed [15:0] record_score;
    logic               is_final;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        sorted_id;
    logic signed [15:0] sorted_score;
    logic               last_of_run;
    logic               overflowed;
  } out_item_t;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [15:0] score;
  } rec_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } emit_t;

endpackage

>>> rtl/core/rsd_engine.sv
module rsd_engine (
  input  logic              clk,
  input  logic              rst,
  input  rsd_pkg::in_item_t record,
  input  logic              record_valid,
  output logic              record_stall,
  output rsd_pkg::emit_t    emit,
  input  logic              emit_ready
);
  import rsd_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HEAD = 3'd1;
  localparam logic [2:0] ST_GRAB = 3'd2;
  localparam logic [2:0] ST_SCAN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  rec_t mem [MAX_RECORDS];
  rec_t rdata;

  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [CNT_W-1:0] fill;
  logic             ovf;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  rec_t             cur;

  logic             accept;
  logic             full;
  logic [CNT_W-1:0] i_plus;
  logic [CNT_W-1:0] j_plus;
  logic             swap;
  logic             is_last;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  rec_t             wr_data;

  assign record_stall = (state != ST_IDLE);
  assign accept       = record_valid && !record_stall;
  assign full         = (fill == CNT_W'(MAX_RECORDS));
  assign i_plus       = {1'b0, i} + CNT_W'(1);
  assign j_plus       = {1'b0, j} + CNT_W'(1);
  assign swap         = ($signed(cur.score) < $signed(rdata.score));
  assign is_last      = (i_plus == fill);

  always_comb begin
    case (state)
      ST_HEAD: rd_addr = i;
      ST_GRAB: rd_addr = i_plus[IDX_W-1:0];
      ST_SCAN: rd_addr = j_plus[IDX_W-1:0];
      default: rd_addr = i;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill[IDX_W-1:0];
    wr_data = '{id: record.record_id, score: record.record_score};
    if (accept && !full) begin
      wr_en = 1'b1;
    end else if (state == ST_SCAN && swap) begin
      wr_en   = 1'b1;
      wr_addr = j;
      wr_data = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && record.is_final) state_next = ST_HEAD;
      end
      ST_HEAD: state_next = ST_GRAB;
      ST_GRAB: begin
        if (i_plus < fill) state_next = ST_SCAN;
        else state_next = ST_EMIT;
      end
      ST_SCAN: begin
        if (j_plus == fill) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_ready) state_next = is_last ? ST_IDLE : ST_HEAD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      ovf   <= 1'b0;
      i     <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (full) ovf <= 1'b1;
        else fill <= fill + CNT_W'(1);
        if (record.is_final) i <= '0;
      end
      if (state == ST_EMIT && emit_ready) begin
        if (is_last) begin
          fill <= '0;
          ovf  <= 1'b0;
        end else begin
          i <= i_plus[IDX_W-1:0];
        end
      end
    end
  end

  // Hold the running record for position i; trade it on every larger score.
  always_ff @(posedge clk) begin
    if (state == ST_GRAB) begin
      cur <= rdata;
      j   <= i_plus[IDX_W-1:0];
    end else if (state == ST_SCAN) begin
      if (swap) cur <= rdata;
      j <= j_plus[IDX_W-1:0];
    end
  end

  always_comb begin
    emit.valid             = (state == ST_EMIT);
    emit.item.sorted_id    = cur.id;
    emit.item.sorted_score = cur.score;
    emit.item.last_of_run  = is_last;
    emit.item.overflowed   = ovf;
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(MAX_RECORDS))
    else $error("fill count beyond capacity");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> (j > i) && (j_plus <= fill))
    else $error("scan index out of range");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    emit.valid |-> fill != '0)
    else $error("emit with empty store");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    emit.valid && emit_ready && emit.item.last_of_run |=> fill == '0 && !ovf)
    else $error("store not emptied after last item");
`endif

endmodule

>>> rtl/core/record_sort_descending.sv
// Sorts a set of records (16-bit id, signed 16-bit score) into descending
// score order. Records load one item per cycle, while record_stall is low,
// into a 32-entry store; the item with is_final set closes the set and
// starts the sort. The sort is an exchange sort on one single-port-read
// memory and one comparator, and each position's record is sent out as
// soon as its pass ends. Records that arrive with the store full are
// dropped and every result of that set carries overflowed; the final item
// still starts the sort when it is dropped. Equal scores are never swapped.
// record_stall stays high from the final item until the last result of the
// set has entered the output register. No clearing pass is needed after
// reset.
module record_sort_descending (
  input  logic               clk,
  input  logic               rst,
  input  rsd_pkg::in_item_t  record,
  input  logic               record_valid,
  output logic               record_stall,
  output rsd_pkg::out_item_t result,
  output logic               result_valid,
  input  logic               result_stall
);
  import rsd_pkg::*;

  emit_t emit;
  logic  emit_ready;

  // Load, sort and pick the next result in order.
  rsd_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .record       (record),
    .record_valid (record_valid),
    .record_stall (record_stall),
    .emit         (emit),
    .emit_ready   (emit_ready)
  );

  // Take a new result whenever the output register is empty or draining.
  assign emit_ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit.valid && emit_ready) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Hold the payload while stalled; advance only when a new item lands.
  always_ff @(posedge clk) begin
    if (emit.valid && emit_ready) begin
      result <= emit.item;
    end
  end

endmodule
